>>> sv/bfm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared types and constants of the 5x5 box filter mean unit.
// ----------------------------------------------------------------------------
package bfm_pkg;

   // pixel and frame geometry
   localparam int PIXEL_W     = 8;
   localparam int DIM_W       = 13;
   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int MIN_DIM     = 5;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int WINDOW_SIZE = 5;
   localparam int LINE_ROWS   = WINDOW_SIZE - 1;
   localparam int WORD_W      = LINE_ROWS * PIXEL_W;

   // reset frame size
   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

   // sums: one column of five pixels, then the whole window
   localparam int COLSUM_W = 11;
   localparam int SUM_W    = 13;

   // floor(sum / 25) as (sum * 5243) >> 17, exact for sums up to 6375
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 17;
   localparam logic [RECIP_W-1:0] RECIP_25 = RECIP_W'(5243);
   localparam int PROD_W      = SUM_W + RECIP_W;

   // register map
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   // per-request flags that travel down the pipeline
   typedef struct packed {
      logic emit;
      logic last;
   } scan_tag_type;

endpackage
`default_nettype wire

>>> sv/bfm_line_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfm_line_store
// Line memory, one word per column holding the four previous rows.
// ----------------------------------------------------------------------------
module bfm_line_store (
   input  wire logic                        clock,
   input  wire logic                        rd_en,
   input  wire logic [bfm_pkg::COL_W-1:0]   rd_addr,
   output logic      [bfm_pkg::WORD_W-1:0]  rd_data,
   input  wire logic                        wr_en,
   input  wire logic [bfm_pkg::COL_W-1:0]   wr_addr,
   input  wire logic [bfm_pkg::WORD_W-1:0]  wr_data
);

   logic [bfm_pkg::WORD_W-1:0] line_mem_ff [bfm_pkg::MAX_WIDTH];
   logic [bfm_pkg::WORD_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> sv/bfm_scan_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfm_scan_ctrl
// Frame size registers, per-frame size latch and raster position counters.
// ----------------------------------------------------------------------------
module bfm_scan_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [bfm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bfm_pkg::DIM_W-1:0]      csr_data,
   input  wire logic                           accept,
   output logic      [bfm_pkg::COL_W-1:0]      cur_col,
   output bfm_pkg::scan_tag_type               cur_tag
);

   localparam logic [bfm_pkg::DIM_W-1:0] DIM_MIN  = bfm_pkg::DIM_W'(bfm_pkg::MIN_DIM);
   localparam logic [bfm_pkg::DIM_W-1:0] WIDTH_MAX = bfm_pkg::DIM_W'(bfm_pkg::MAX_WIDTH);
   localparam logic [bfm_pkg::DIM_W-1:0] HEIGHT_MAX =
      bfm_pkg::DIM_W'(bfm_pkg::MAX_HEIGHT);
   localparam logic [bfm_pkg::COL_W-1:0] COL_FIRST_OUT =
      bfm_pkg::COL_W'(bfm_pkg::WINDOW_SIZE - 1);
   localparam logic [bfm_pkg::ROW_W-1:0] ROW_FIRST_OUT =
      bfm_pkg::ROW_W'(bfm_pkg::WINDOW_SIZE - 1);

   logic [bfm_pkg::DIM_W-1:0] width_cfg_ff;
   logic [bfm_pkg::DIM_W-1:0] height_cfg_ff;
   logic [bfm_pkg::DIM_W-1:0] frame_w_ff;
   logic [bfm_pkg::DIM_W-1:0] frame_h_ff;
   logic [bfm_pkg::COL_W-1:0] col_ff;
   logic [bfm_pkg::ROW_W-1:0] row_ff;
   logic [bfm_pkg::COL_W-1:0] col_in;
   logic [bfm_pkg::ROW_W-1:0] row_in;

   logic                      frame_start;
   logic [bfm_pkg::DIM_W-1:0] eff_w;
   logic [bfm_pkg::DIM_W-1:0] eff_h;
   logic [bfm_pkg::DIM_W-1:0] w_clamped;
   logic [bfm_pkg::DIM_W-1:0] h_clamped;
   logic                      col_last;
   logic                      row_last;

   // clamp configured sizes into the supported range
   always_comb begin
      if (width_cfg_ff < DIM_MIN) begin
         w_clamped = DIM_MIN;
      end else if (width_cfg_ff > WIDTH_MAX) begin
         w_clamped = WIDTH_MAX;
      end else begin
         w_clamped = width_cfg_ff;
      end
      if (height_cfg_ff < DIM_MIN) begin
         h_clamped = DIM_MIN;
      end else if (height_cfg_ff > HEIGHT_MAX) begin
         h_clamped = HEIGHT_MAX;
      end else begin
         h_clamped = height_cfg_ff;
      end
   end

   // the first pixel of a frame uses the fresh size, later ones the latched size
   assign frame_start = (col_ff == '0) && (row_ff == '0);
   assign eff_w = frame_start ? w_clamped : frame_w_ff;
   assign eff_h = frame_start ? h_clamped : frame_h_ff;

   assign col_last = ({1'b0, col_ff} + bfm_pkg::DIM_W'(1)) >= eff_w;
   assign row_last = ({1'b0, row_ff} + bfm_pkg::DIM_W'(1)) >= eff_h;

   // next raster position
   always_comb begin
      col_in = col_ff + bfm_pkg::COL_W'(1);
      row_in = row_ff;
      if (col_last) begin
         col_in = '0;
         row_in = row_last ? '0 : row_ff + bfm_pkg::ROW_W'(1);
      end
   end

   // registers and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= bfm_pkg::WIDTH_RESET;
         height_cfg_ff <= bfm_pkg::HEIGHT_RESET;
         frame_w_ff    <= bfm_pkg::WIDTH_RESET;
         frame_h_ff    <= bfm_pkg::HEIGHT_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               bfm_pkg::CSR_IMAGE_WIDTH:  width_cfg_ff  <= csr_data;
               bfm_pkg::CSR_IMAGE_HEIGHT: height_cfg_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            if (frame_start) begin
               frame_w_ff <= w_clamped;
               frame_h_ff <= h_clamped;
            end
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   assign cur_col      = col_ff;
   assign cur_tag.emit = (row_ff >= ROW_FIRST_OUT) && (col_ff >= COL_FIRST_OUT);
   assign cur_tag.last = col_last && row_last;

endmodule
`default_nettype wire

>>> sv/bfm_window_sum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfm_window_sum
// Column sums and 5x5 window sum, two pipeline stages.
// ----------------------------------------------------------------------------
module bfm_window_sum (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          in_valid,
   input  wire logic [bfm_pkg::PIXEL_W-1:0]   in_pixel,
   input  wire logic [bfm_pkg::WORD_W-1:0]    line_word,
   input  wire bfm_pkg::scan_tag_type         in_tag,
   output logic                               sum_valid,
   output logic      [bfm_pkg::SUM_W-1:0]     sum_value,
   output bfm_pkg::scan_tag_type              sum_tag
);

   logic [bfm_pkg::COLSUM_W-1:0] col_sum_in;
   logic                         col_valid_ff;
   logic [bfm_pkg::COLSUM_W-1:0] col_sum_ff;
   bfm_pkg::scan_tag_type        col_tag_ff;

   logic [bfm_pkg::COLSUM_W-1:0] hist_ff [bfm_pkg::WINDOW_SIZE-1];
   logic [bfm_pkg::SUM_W-1:0]    total_ff;
   logic [bfm_pkg::SUM_W-1:0]    total_in;
   logic                         sum_valid_ff;
   bfm_pkg::scan_tag_type        sum_tag_ff;

   // new column: four stored rows plus the arriving pixel
   always_comb begin
      col_sum_in = bfm_pkg::COLSUM_W'(in_pixel);
      for (int r = 0; r < bfm_pkg::LINE_ROWS; r++) begin
         col_sum_in = col_sum_in +
            bfm_pkg::COLSUM_W'(line_word[r*bfm_pkg::PIXEL_W +: bfm_pkg::PIXEL_W]);
      end
   end

   // column stage
   always_ff @(posedge clock) begin
      if (reset) begin
         col_valid_ff <= 1'b0;
      end else if (advance) begin
         col_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         col_sum_ff <= col_sum_in;
         col_tag_ff <= in_tag;
      end
   end

   // window sum: newest column plus the four columns before it
   always_comb begin
      total_in = bfm_pkg::SUM_W'(col_sum_ff);
      for (int k = 0; k < bfm_pkg::WINDOW_SIZE - 1; k++) begin
         total_in = total_in + bfm_pkg::SUM_W'(hist_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         total_ff     <= '0;
         for (int k = 0; k < bfm_pkg::WINDOW_SIZE - 1; k++) begin
            hist_ff[k] <= '0;
         end
      end else if (advance) begin
         sum_valid_ff <= col_valid_ff;
         if (col_valid_ff) begin
            total_ff <= total_in;
            for (int k = 0; k < bfm_pkg::WINDOW_SIZE - 2; k++) begin
               hist_ff[k] <= hist_ff[k+1];
            end
            hist_ff[bfm_pkg::WINDOW_SIZE-2] <= col_sum_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && col_valid_ff) begin
         sum_tag_ff <= col_tag_ff;
      end
   end

   assign sum_valid = sum_valid_ff;
   assign sum_value = total_ff;
   assign sum_tag   = sum_tag_ff;

endmodule
`default_nettype wire

>>> sv/box_filter_5x5_mean_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// box_filter_5x5_mean_unit
// Streaming 5x5 box filter giving the truncated mean of interior pixels.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one 8-bit pixel per request, frames in raster order, one
//   frame right after the other. rsp_* gives floor(sum/25) of the 5x5 window
//   for every interior pixel, when the window's bottom-right pixel arrives;
//   border pixels give no response. rsp_last_of_frame marks the frame's
//   final response. csr_* writes image_width (index 0) and image_height
//   (index 1); the size is sampled at the first pixel of each frame.
//   Throughput is one pixel per clock while no response is stalled. Once a
//   request is accepted, the accepting edge reads the line memory, then the
//   column sum, the window sum, and the reciprocal multiply into the output
//   register. The line memory has one read and one write port; consecutive
//   pixels hit different columns.
//   Reset clears the pipeline, the window and the raster position and loads
//   640x480; the line memory is not cleared and needs no clearing pass.
//   When the receiver stalls with a response waiting, the whole pipeline
//   holds and req_ready drops until the response is taken.
// ----------------------------------------------------------------------------
module box_filter_5x5_mean_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [bfm_pkg::PIXEL_W-1:0]    req_pixel,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [bfm_pkg::PIXEL_W-1:0]    rsp_mean_value,
   output logic                                rsp_last_of_frame,
   input  wire logic                           csr_wr_en,
   input  wire logic [bfm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bfm_pkg::DIM_W-1:0]      csr_data
);

   logic                          advance;
   logic                          accept;
   logic [bfm_pkg::COL_W-1:0]     cur_col;
   bfm_pkg::scan_tag_type         cur_tag;

   logic                          s1_valid_ff;
   logic [bfm_pkg::PIXEL_W-1:0]   s1_pixel_ff;
   logic [bfm_pkg::COL_W-1:0]     s1_col_ff;
   bfm_pkg::scan_tag_type         s1_tag_ff;

   logic [bfm_pkg::WORD_W-1:0]    line_word;
   logic                          wr_en;
   logic [bfm_pkg::WORD_W-1:0]    wr_word;

   logic                          sum_valid;
   logic [bfm_pkg::SUM_W-1:0]     sum_value;
   bfm_pkg::scan_tag_type         sum_tag;
   logic [bfm_pkg::PROD_W-1:0]    product;

   logic                          rsp_valid_ff;
   logic [bfm_pkg::PIXEL_W-1:0]   rsp_mean_ff;
   logic                          rsp_last_ff;

   // the pipeline moves whenever the output register is free or being emptied
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   // raster position and frame size
   bfm_scan_ctrl u_scan_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .accept    (accept),
      .cur_col   (cur_col),
      .cur_tag   (cur_tag)
   );

   // stage 1 holds the request while the line word is read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_pixel;
         s1_col_ff   <= cur_col;
         s1_tag_ff   <= cur_tag;
      end
   end

   // drop the oldest row, push the new pixel into the newest byte
   assign wr_en   = advance && s1_valid_ff;
   assign wr_word = {s1_pixel_ff, line_word[bfm_pkg::WORD_W-1:bfm_pkg::PIXEL_W]};

   bfm_line_store u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (line_word),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (wr_word)
   );

   // column sums and window sum
   bfm_window_sum u_window_sum (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s1_valid_ff),
      .in_pixel  (s1_pixel_ff),
      .line_word (line_word),
      .in_tag    (s1_tag_ff),
      .sum_valid (sum_valid),
      .sum_value (sum_value),
      .sum_tag   (sum_tag)
   );

   // divide by 25 through the reciprocal
   assign product = bfm_pkg::PROD_W'(sum_value) * bfm_pkg::PROD_W'(bfm_pkg::RECIP_25);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= sum_valid && sum_tag.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && sum_valid) begin
         rsp_mean_ff <= product[bfm_pkg::RECIP_SHIFT +: bfm_pkg::PIXEL_W];
         rsp_last_ff <= sum_tag.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mean_value    = rsp_mean_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   // a waiting response blocks new requests
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while response stalled");

   // read and write of the line memory never meet at one column
   assert property (@(posedge clock) disable iff (reset)
      (wr_en && accept) |-> (s1_col_ff != cur_col))
      else $error("line memory read and write collide");

   // a stalled pipeline keeps its first stage
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s1_valid_ff))
      else $error("stage 1 changed during stall");

endmodule
`default_nettype wire

>>> tb/sv/box_filter_5x5_mean_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_filter_5x5_mean_unit_tb
// Self-checking bench for the 5x5 box filter mean unit. A driver streams
// frames of pixels from a queue and a window-sum predictor works out the
// mean of every interior pixel. A monitor checks each response field by
// field while both sides idle at random. Frame sizes change between frames,
// halfway through a frame, and are clamped up from below the minimum.
// ----------------------------------------------------------------------------
module box_filter_5x5_mean_unit_tb;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_ITEMS  = 1200;

   typedef enum int {
      FILL_RANDOM,
      FILL_EXTREME,
      FILL_FLAT,
      FILL_BRIGHT
   } fill_mode_type;

   typedef struct packed {
      logic [bfm_pkg::PIXEL_W-1:0] mean;
      logic                        last;
   } window_mean_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [bfm_pkg::PIXEL_W-1:0]   req_pixel = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [bfm_pkg::PIXEL_W-1:0]   rsp_mean_value;
   logic                          rsp_last_of_frame;
   logic                          csr_wr_en = 1'b0;
   logic [bfm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bfm_pkg::DIM_W-1:0]     csr_data = '0;

   // pending pixels and expected means
   logic [bfm_pkg::PIXEL_W-1:0] pixel_q[$];
   window_mean_type             expected_means[$];
   int                          pushed_count = 0;
   int                          accepted_count = 0;
   int                          send_idle_pct = 0;
   int                          recv_idle_pct = 0;
   int                          error_count = 0;
   int                          stall_cycles = 0;

   // predictor copy of the registers, raster position and window
   logic [bfm_pkg::DIM_W-1:0]   width_reg = bfm_pkg::WIDTH_RESET;
   logic [bfm_pkg::DIM_W-1:0]   height_reg = bfm_pkg::HEIGHT_RESET;
   int                          frame_cols = 640;
   int                          frame_rows = 480;
   int                          col_pos = 0;
   int                          row_pos = 0;
   logic [bfm_pkg::WORD_W-1:0]  row_hist [bfm_pkg::MAX_WIDTH];
   logic [bfm_pkg::PIXEL_W-1:0] tap_win [bfm_pkg::WINDOW_SIZE][bfm_pkg::WINDOW_SIZE];

   box_filter_5x5_mean_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel         (req_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_mean_value    (rsp_mean_value),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int limit_dim(input logic [bfm_pkg::DIM_W-1:0] v, input int hi);
      if (v < bfm_pkg::MIN_DIM) return bfm_pkg::MIN_DIM;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   // window mean of one accepted pixel, pushed when the pixel completes a window
   task automatic window_mean_predict(input logic [bfm_pkg::PIXEL_W-1:0] px);
      logic [bfm_pkg::WORD_W-1:0] word;
      int                         total;
      window_mean_type            want;
      // frame size is taken only at the first pixel of a frame
      if (col_pos == 0 && row_pos == 0) begin
         frame_cols = limit_dim(width_reg, bfm_pkg::MAX_WIDTH);
         frame_rows = limit_dim(height_reg, bfm_pkg::MAX_HEIGHT);
      end
      word = row_hist[col_pos];
      // slide left, new column enters on the right, oldest row on top
      for (int r = 0; r < bfm_pkg::WINDOW_SIZE; r++) begin
         for (int k = 0; k < bfm_pkg::WINDOW_SIZE - 1; k++)
            tap_win[r][k] = tap_win[r][k+1];
         tap_win[r][bfm_pkg::WINDOW_SIZE-1] = (r < bfm_pkg::LINE_ROWS) ?
            word[r*bfm_pkg::PIXEL_W +: bfm_pkg::PIXEL_W] : px;
      end
      row_hist[col_pos] = {px, word[bfm_pkg::WORD_W-1:bfm_pkg::PIXEL_W]};
      if (row_pos >= bfm_pkg::WINDOW_SIZE - 1 && col_pos >= bfm_pkg::WINDOW_SIZE - 1) begin
         total = 0;
         for (int r = 0; r < bfm_pkg::WINDOW_SIZE; r++)
            for (int k = 0; k < bfm_pkg::WINDOW_SIZE; k++)
               total += tap_win[r][k];
         want.mean = bfm_pkg::PIXEL_W'(total / (bfm_pkg::WINDOW_SIZE * bfm_pkg::WINDOW_SIZE));
         want.last = (row_pos + 1 >= frame_rows) && (col_pos + 1 >= frame_cols);
         expected_means.push_back(want);
      end
      // raster advance
      if (col_pos + 1 >= frame_cols) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= frame_rows) ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end
   endtask

   // request driver
   always @(posedge clock) begin : drive_pixels
      logic busy;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            window_mean_predict(req_pixel);
            accepted_count++;
         end
         busy = req_valid && !req_ready;
         if (!busy) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_pixel <= pixel_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : check_means
      window_mean_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_means.size() == 0) begin
               $display("%0t: unexpected response, actual mean %0d last %0b",
                        $time, rsp_mean_value, rsp_last_of_frame);
               error_count++;
            end else begin
               want = expected_means.pop_front();
               if (rsp_mean_value !== want.mean) begin
                  $display("%0t: mean_value expected %0d actual %0d",
                           $time, want.mean, rsp_mean_value);
                  error_count++;
               end
               if (rsp_last_of_frame !== want.last) begin
                  $display("%0t: last_of_frame expected %0b actual %0b",
                           $time, want.last, rsp_last_of_frame);
                  error_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles with no progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [bfm_pkg::PIXEL_W-1:0] fill_pixel(
      input fill_mode_type mode, input logic [bfm_pkg::PIXEL_W-1:0] level);
      case (mode)
         FILL_EXTREME: return ($urandom_range(1) != 0) ? '1 : '0;
         FILL_FLAT:    return level;
         FILL_BRIGHT:  return bfm_pkg::PIXEL_W'($urandom_range(255, 224));
         default:      return bfm_pkg::PIXEL_W'($urandom);
      endcase
   endfunction

   function automatic logic [bfm_pkg::DIM_W-1:0] pick_dim(input int hi);
      // now and then a size below the minimum, clamped up by the unit
      if ($urandom_range(7) == 0)
         return bfm_pkg::DIM_W'($urandom_range(bfm_pkg::MIN_DIM - 1));
      return bfm_pkg::DIM_W'($urandom_range(hi, bfm_pkg::MIN_DIM));
   endfunction

   task automatic push_pixels(input int count, input fill_mode_type mode,
                              input logic [bfm_pkg::PIXEL_W-1:0] level);
      for (int i = 0; i < count; i++)
         pixel_q.push_back(fill_pixel(mode, level));
      pushed_count += count;
   endtask

   // all requests taken, all means back, then let the pipeline settle
   task automatic wait_idle();
      while (accepted_count != pushed_count) @(posedge clock);
      while (expected_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [bfm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bfm_pkg::DIM_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == bfm_pkg::CSR_IMAGE_WIDTH)
         width_reg = val;
      else
         height_reg = val;
   endtask

   // whole frames of random content at random sizes
   task automatic run_frames(input int target);
      int                          sent;
      int                          n;
      int                          cut;
      fill_mode_type               mode;
      logic [bfm_pkg::PIXEL_W-1:0] level;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(1) == 0) begin
            wait_idle();
            if ($urandom_range(3) != 0) write_csr(bfm_pkg::CSR_IMAGE_WIDTH, pick_dim(24));
            if ($urandom_range(3) != 0) write_csr(bfm_pkg::CSR_IMAGE_HEIGHT, pick_dim(10));
         end
         n = limit_dim(width_reg, bfm_pkg::MAX_WIDTH) *
             limit_dim(height_reg, bfm_pkg::MAX_HEIGHT);
         mode = fill_mode_type'($urandom_range(FILL_BRIGHT));
         level = bfm_pkg::PIXEL_W'($urandom);
         if ($urandom_range(4) == 0) begin
            // sender holds mid-frame until drained; a new size waits for the next frame
            cut = $urandom_range(n - 1, 1);
            push_pixels(cut, mode, level);
            wait_idle();
            if ($urandom_range(1) == 0) write_csr(bfm_pkg::CSR_IMAGE_HEIGHT, pick_dim(10));
            push_pixels(n - cut, mode, level);
         end else begin
            push_pixels(n, mode, level);
         end
         sent += n;
      end
      wait_idle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // white frame, size clamped up from 3x4 to 5x5
      send_idle_pct = 19;
      recv_idle_pct = 86;
      write_csr(bfm_pkg::CSR_IMAGE_WIDTH, bfm_pkg::DIM_W'(3));
      write_csr(bfm_pkg::CSR_IMAGE_HEIGHT, bfm_pkg::DIM_W'(4));
      push_pixels(25, FILL_FLAT, '1);
      // black frame with a size write halfway through
      push_pixels(12, FILL_FLAT, '0);
      wait_idle();
      write_csr(bfm_pkg::CSR_IMAGE_WIDTH, bfm_pkg::DIM_W'(6));
      write_csr(bfm_pkg::CSR_IMAGE_HEIGHT, bfm_pkg::DIM_W'(6));
      push_pixels(13, FILL_FLAT, '0);
      wait_idle();

      run_frames(RANDOM_ITEMS / 3);
      send_idle_pct = 86;
      recv_idle_pct = 19;
      run_frames(RANDOM_ITEMS / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_frames(RANDOM_ITEMS / 3);

      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
